>>> rtl/tpi_pkg.sv
// Shared widths, codes and types of the triangle and plane intersection block.
package tpi_pkg;

    localparam int CW    = 32;        // coordinate width, Q16.16
    localparam int PRODW = 64;        // coefficient times coordinate
    localparam int FW    = 36;        // plane value width
    localparam int DW    = 37;        // plane value difference width
    localparam int DFW   = 33;        // coordinate difference width
    localparam int PW    = 70;        // interpolation product width
    localparam int QW    = 41;        // quotient bits, limit is 2^40
    localparam int CMPW  = DW + QW;   // divider compare width
    localparam int EPSW  = 16;
    localparam int CFG_AW = 3;
    localparam int BRW   = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_AW-1:0] REG_COEF_X   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_COEF_Y   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_COEF_Z   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_COEF_OFF = 3'd3;
    localparam logic [CFG_AW-1:0] REG_EPSILON  = 3'd4;

    // Result classes.
    localparam logic [2:0] HC_NONE  = 3'd0;
    localparam logic [2:0] HC_TWO   = 3'd1;
    localparam logic [2:0] HC_VERT  = 3'd2;
    localparam logic [2:0] HC_VEDGE = 3'd3;
    localparam logic [2:0] HC_EDGE  = 3'd4;
    localparam logic [2:0] HC_FACE  = 3'd5;

    // Branches of the classification, in test order.
    localparam logic [BRW-1:0] BR_NONE     = 4'd0;
    localparam logic [BRW-1:0] BR_CROSS_LO = 4'd1;
    localparam logic [BRW-1:0] BR_CROSS_HI = 4'd2;
    localparam logic [BRW-1:0] BR_V0       = 4'd3;
    localparam logic [BRW-1:0] BR_V2       = 4'd4;
    localparam logic [BRW-1:0] BR_V1E      = 4'd5;
    localparam logic [BRW-1:0] BR_E01      = 4'd6;
    localparam logic [BRW-1:0] BR_E12      = 4'd7;
    localparam logic [BRW-1:0] BR_FACE     = 4'd8;

    typedef struct packed {
        logic [2:0][CW-1:0] pt;
        logic               pv;
        logic [2:0]         hc;
        logic               last;
    } t_result;

    typedef struct packed {
        t_result res;
        logic    use_b;
    } t_meta;

endpackage

>>> rtl/triangle_plane_intersection.sv
// Triangle and plane intersection pipeline: plane evaluation, sort, classify, interpolate.
// Each triangle yields one to three result items, one per cycle unless the output stalls, and
// the block takes a new triangle only as the last of them leaves the classifier stage. A
// triangle holds the classifier stage until it has issued all its points, because the single
// result lane after the classifier takes one point per cycle while the output is not stalled.
// The result lane holds one restoring divider per coordinate, fully pipelined at one quotient
// bit per stage.
// Configuration may be written only while no item is in flight.
module triangle_plane_intersection (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [31:0]         i_corner0_x,
    input  logic signed [31:0]         i_corner0_y,
    input  logic signed [31:0]         i_corner0_z,
    input  logic signed [31:0]         i_corner1_x,
    input  logic signed [31:0]         i_corner1_y,
    input  logic signed [31:0]         i_corner1_z,
    input  logic signed [31:0]         i_corner2_x,
    input  logic signed [31:0]         i_corner2_y,
    input  logic signed [31:0]         i_corner2_z,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [31:0]         o_point_x,
    output logic signed [31:0]         o_point_y,
    output logic signed [31:0]         o_point_z,
    output logic                       o_point_valid,
    output logic [2:0]                 o_hit_case,
    output logic                       o_tri_end,
    input  logic                       i_cfg_we,
    input  logic [tpi_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [31:0]                i_cfg_wdata
);

    localparam int CW   = tpi_pkg::CW;
    localparam int FW   = tpi_pkg::FW;
    localparam int DW   = tpi_pkg::DW;
    localparam int DFW  = tpi_pkg::DFW;
    localparam int PW   = tpi_pkg::PW;
    localparam int QW   = tpi_pkg::QW;
    localparam int CMPW = tpi_pkg::CMPW;
    localparam int PRODW = tpi_pkg::PRODW;
    localparam int EPSW = tpi_pkg::EPSW;
    localparam int BRW  = tpi_pkg::BRW;
    localparam int SW   = QW + 2;
    localparam logic [QW-1:0] QLIM = QW'(1) << (QW - 1);

    // Configuration.
    logic signed [CW-1:0] r_coef_x, r_coef_y, r_coef_z, r_coef_off;
    logic [EPSW-1:0]      r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_x   <= '0;
            r_coef_y   <= '0;
            r_coef_z   <= '0;
            r_coef_off <= '0;
            r_eps      <= EPSW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tpi_pkg::REG_COEF_X:   r_coef_x   <= i_cfg_wdata;
                tpi_pkg::REG_COEF_Y:   r_coef_y   <= i_cfg_wdata;
                tpi_pkg::REG_COEF_Z:   r_coef_z   <= i_cfg_wdata;
                tpi_pkg::REG_COEF_OFF: r_coef_off <= i_cfg_wdata;
                tpi_pkg::REG_EPSILON:  r_eps      <= i_cfg_wdata[EPSW-1:0];
                default: ;
            endcase
        end
    end

    // Flow control.
    logic [1:0] r_ocnt;
    logic       en;
    logic       front_adv;
    logic       sel_last;

    logic r_f1_v, r_f2_v, r_f3_v, r_f4_v, r_f5_v, r_f6_v, r_s_v;
    logic [1:0] r_idx;
    logic [1:0] r_s_cnt;

    assign en        = (r_ocnt != 2'd2);
    assign sel_last  = (r_idx == (r_s_cnt - 2'd1));
    assign front_adv = en && (!r_s_v || sel_last);
    assign o_in_stall = !front_adv;

    // Front stages.
    logic signed [CW-1:0]    r_f1_p [3][3];
    logic signed [CW-1:0]    r_f2_p [3][3];
    logic signed [PRODW-1:0] r_f2_m [3][3];
    logic signed [CW-1:0]    r_f3_p [3][3];
    logic signed [FW-1:0]    r_f3_f [3];
    logic signed [CW-1:0]    r_f4_p [3][3];
    logic signed [FW-1:0]    r_f4_f [3];
    logic signed [CW-1:0]    r_f5_p [3][3];
    logic signed [FW-1:0]    r_f5_f [3];
    logic signed [CW-1:0]    r_f6_p [3][3];
    logic signed [FW-1:0]    r_f6_f [3];
    logic signed [CW-1:0]    r_s_p [3][3];
    logic signed [FW-1:0]    r_s_f [3];
    logic [BRW-1:0]          r_s_br;

    logic signed [CW-1:0]    n_f4_p [3][3];
    logic signed [FW-1:0]    n_f4_f [3];
    logic signed [CW-1:0]    n_f5_p [3][3];
    logic signed [FW-1:0]    n_f5_f [3];
    logic signed [CW-1:0]    n_f6_p [3][3];
    logic signed [FW-1:0]    n_f6_f [3];
    logic [BRW-1:0]          n_s_br;
    logic [1:0]              n_s_cnt;

    // Compare-swaps swap only on a strict greater-than.
    always_comb begin
        n_f4_p = r_f3_p;
        n_f4_f = r_f3_f;
        if (r_f3_f[0] > r_f3_f[1]) begin
            n_f4_p[0] = r_f3_p[1];
            n_f4_p[1] = r_f3_p[0];
            n_f4_f[0] = r_f3_f[1];
            n_f4_f[1] = r_f3_f[0];
        end
        n_f5_p = r_f4_p;
        n_f5_f = r_f4_f;
        if (r_f4_f[1] > r_f4_f[2]) begin
            n_f5_p[1] = r_f4_p[2];
            n_f5_p[2] = r_f4_p[1];
            n_f5_f[1] = r_f4_f[2];
            n_f5_f[2] = r_f4_f[1];
        end
        n_f6_p = r_f5_p;
        n_f6_f = r_f5_f;
        if (r_f5_f[0] > r_f5_f[1]) begin
            n_f6_p[0] = r_f5_p[1];
            n_f6_p[1] = r_f5_p[0];
            n_f6_f[0] = r_f5_f[1];
            n_f6_f[1] = r_f5_f[0];
        end
    end

    // Classification of the sorted plane values.
    logic signed [FW-1:0] es, nes, f0, f1, f2;
    logic                 n0, n1, n2;

    always_comb begin
        es  = $signed({{(FW-EPSW){1'b0}}, r_eps});
        nes = -es;
        f0  = r_f6_f[0];
        f1  = r_f6_f[1];
        f2  = r_f6_f[2];
        n0  = (f0 > nes) && (f0 < es);
        n1  = (f1 > nes) && (f1 < es);
        n2  = (f2 > nes) && (f2 < es);
        n_s_br  = tpi_pkg::BR_NONE;
        n_s_cnt = 2'd1;
        if (f0 > 0 || f2 < 0) begin
            n_s_br = tpi_pkg::BR_NONE;
        end else if (f0 < es && f1 > es) begin
            n_s_br  = tpi_pkg::BR_CROSS_LO;
            n_s_cnt = 2'd2;
        end else if (f1 < es && f2 > es) begin
            n_s_br  = tpi_pkg::BR_CROSS_HI;
            n_s_cnt = 2'd2;
        end else if (n0 && f1 > es) begin
            n_s_br = tpi_pkg::BR_V0;
        end else if (n2 && f1 < es) begin
            n_s_br = tpi_pkg::BR_V2;
        end else if (f0 < nes && n1 && f2 > es) begin
            n_s_br  = tpi_pkg::BR_V1E;
            n_s_cnt = 2'd2;
        end else if (n0 && n1 && f2 > es) begin
            n_s_br  = tpi_pkg::BR_E01;
            n_s_cnt = 2'd2;
        end else if (n1 && n2 && f0 < es) begin
            n_s_br  = tpi_pkg::BR_E12;
            n_s_cnt = 2'd2;
        end else if (n0 && n1 && n2) begin
            n_s_br  = tpi_pkg::BR_FACE;
            n_s_cnt = 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
            r_f4_v <= 1'b0;
            r_f5_v <= 1'b0;
            r_f6_v <= 1'b0;
            r_s_v  <= 1'b0;
            r_idx  <= 2'd0;
        end else if (front_adv) begin
            r_f1_v <= i_in_valid;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
            r_f4_v <= r_f3_v;
            r_f5_v <= r_f4_v;
            r_f6_v <= r_f5_v;
            r_s_v  <= r_f6_v;
            r_idx  <= 2'd0;
        end else if (en && r_s_v) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_adv) begin
            r_f1_p[0][0] <= i_corner0_x;
            r_f1_p[0][1] <= i_corner0_y;
            r_f1_p[0][2] <= i_corner0_z;
            r_f1_p[1][0] <= i_corner1_x;
            r_f1_p[1][1] <= i_corner1_y;
            r_f1_p[1][2] <= i_corner1_z;
            r_f1_p[2][0] <= i_corner2_x;
            r_f1_p[2][1] <= i_corner2_y;
            r_f1_p[2][2] <= i_corner2_z;
            r_f2_p <= r_f1_p;
            for (int i = 0; i < 3; i++) begin
                r_f2_m[i][0] <= PRODW'(r_coef_x) * PRODW'(r_f1_p[i][0]);
                r_f2_m[i][1] <= PRODW'(r_coef_y) * PRODW'(r_f1_p[i][1]);
                r_f2_m[i][2] <= PRODW'(r_coef_z) * PRODW'(r_f1_p[i][2]);
                // Each product is floored by 2^30 before the sum.
                r_f3_f[i] <= FW'(r_f2_m[i][0] >>> 30) + FW'(r_f2_m[i][1] >>> 30)
                           + FW'(r_f2_m[i][2] >>> 30) + FW'(r_coef_off);
            end
            r_f3_p  <= r_f2_p;
            r_f4_p  <= n_f4_p;
            r_f4_f  <= n_f4_f;
            r_f5_p  <= n_f5_p;
            r_f5_f  <= n_f5_f;
            r_f6_p  <= n_f6_p;
            r_f6_f  <= n_f6_f;
            r_s_p   <= r_f6_p;
            r_s_f   <= r_f6_f;
            r_s_br  <= n_s_br;
            r_s_cnt <= n_s_cnt;
        end
    end

    // Result selection: which corners feed the current result item.
    logic [1:0] sel_a, sel_b;
    logic       is_cross;
    logic [2:0] d_hc;
    logic       d_pv;

    always_comb begin
        sel_a    = 2'd0;
        sel_b    = 2'd0;
        is_cross = 1'b0;
        d_hc     = tpi_pkg::HC_NONE;
        d_pv     = 1'b1;
        case (r_s_br)
            tpi_pkg::BR_CROSS_LO: begin
                is_cross = 1'b1;
                sel_a    = 2'd0;
                sel_b    = (r_idx == 2'd0) ? 2'd1 : 2'd2;
                d_hc     = tpi_pkg::HC_TWO;
            end
            tpi_pkg::BR_CROSS_HI: begin
                is_cross = 1'b1;
                sel_a    = 2'd2;
                sel_b    = (r_idx == 2'd0) ? 2'd0 : 2'd1;
                d_hc     = tpi_pkg::HC_TWO;
            end
            tpi_pkg::BR_V0: begin
                sel_b = 2'd0;
                d_hc  = tpi_pkg::HC_VERT;
            end
            tpi_pkg::BR_V2: begin
                sel_b = 2'd2;
                d_hc  = tpi_pkg::HC_VERT;
            end
            tpi_pkg::BR_V1E: begin
                d_hc = tpi_pkg::HC_VEDGE;
                if (r_idx == 2'd0) begin
                    sel_b = 2'd1;
                end else begin
                    is_cross = 1'b1;
                    sel_a    = 2'd0;
                    sel_b    = 2'd2;
                end
            end
            tpi_pkg::BR_E01: begin
                sel_b = (r_idx == 2'd0) ? 2'd0 : 2'd1;
                d_hc  = tpi_pkg::HC_EDGE;
            end
            tpi_pkg::BR_E12: begin
                sel_b = (r_idx == 2'd0) ? 2'd1 : 2'd2;
                d_hc  = tpi_pkg::HC_EDGE;
            end
            tpi_pkg::BR_FACE: begin
                sel_b = r_idx;
                d_hc  = tpi_pkg::HC_FACE;
            end
            default: begin
                d_pv = 1'b0;
            end
        endcase
    end

    // Result lane.
    logic                  r_p1_v, r_p2_v, r_p3_v, r_pf_v;
    logic signed [DW-1:0]  r_p1_den, r_p1_nfb, r_p2_den;
    logic signed [DFW-1:0] r_p1_diff [3];
    logic signed [PW-1:0]  r_p2_prod [3];
    logic [PW-1:0]         r_p3_mag [3];
    logic                  r_p3_neg [3];
    logic [DW-1:0]         r_p3_dmag;
    tpi_pkg::t_meta        r_p1_m, r_p2_m, r_p3_m, r_pf_m;
    logic signed [QW:0]    r_pf_q [3];

    logic [PW-1:0]   r_rem  [QW+1][3];
    logic [QW-1:0]   r_q    [QW+1][3];
    logic            r_neg  [QW+1][3];
    logic            r_ovr  [QW+1][3];
    logic [DW-1:0]   r_dv   [QW+1];
    tpi_pkg::t_meta  r_dm   [QW+1];
    logic            r_dvld [QW+1];

    tpi_pkg::t_meta       n_p1_m;
    logic signed [FW-1:0] d_fa, d_fb;

    always_comb begin
        d_fa = r_s_f[sel_a];
        d_fb = r_s_f[sel_b];
        n_p1_m.use_b    = !is_cross || (d_fa == d_fb);
        n_p1_m.res.pv   = d_pv;
        n_p1_m.res.hc   = d_hc;
        n_p1_m.res.last = sel_last;
        for (int c = 0; c < 3; c++) begin
            n_p1_m.res.pt[c] = d_pv ? r_s_p[sel_b][c] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_pf_v <= 1'b0;
            for (int s = 0; s <= QW; s++) begin
                r_dvld[s] <= 1'b0;
            end
        end else if (en) begin
            r_p1_v    <= r_s_v;
            r_p2_v    <= r_p1_v;
            r_p3_v    <= r_p2_v;
            r_dvld[0] <= r_p3_v;
            for (int s = 1; s <= QW; s++) begin
                r_dvld[s] <= r_dvld[s-1];
            end
            r_pf_v <= r_dvld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_den <= DW'(d_fa) - DW'(d_fb);
            r_p1_nfb <= -DW'(d_fb);
            for (int c = 0; c < 3; c++) begin
                r_p1_diff[c] <= DFW'(r_s_p[sel_a][c]) - DFW'(r_s_p[sel_b][c]);
            end
            r_p1_m <= n_p1_m;

            for (int c = 0; c < 3; c++) begin
                r_p2_prod[c] <= PW'(r_p1_nfb) * PW'(r_p1_diff[c]);
            end
            r_p2_den <= r_p1_den;
            r_p2_m   <= r_p1_m;

            for (int c = 0; c < 3; c++) begin
                r_p3_mag[c] <= r_p2_prod[c][PW-1] ? PW'(-r_p2_prod[c]) : PW'(r_p2_prod[c]);
                r_p3_neg[c] <= r_p2_prod[c][PW-1] ^ r_p2_den[DW-1];
            end
            r_p3_dmag <= r_p2_den[DW-1] ? DW'(-r_p2_den) : DW'(r_p2_den);
            r_p3_m    <= r_p2_m;

            // A quotient of 2^41 or more is flagged here and clamped at the end.
            for (int c = 0; c < 3; c++) begin
                r_rem[0][c] <= r_p3_mag[c];
                r_q[0][c]   <= '0;
                r_neg[0][c] <= r_p3_neg[c];
                r_ovr[0][c] <= CMPW'(r_p3_mag[c]) >= (CMPW'(r_p3_dmag) << QW);
            end
            r_dv[0] <= r_p3_dmag;
            r_dm[0] <= r_p3_m;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 1; s <= QW; s++) begin : g_div
        logic [CMPW-1:0] w_sh [3];
        logic            w_ge [3];

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                w_sh[c] = CMPW'(r_dv[s-1]) << (QW - s);
                w_ge[c] = CMPW'(r_rem[s-1][c]) >= w_sh[c];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int c = 0; c < 3; c++) begin
                    r_rem[s][c] <= w_ge[c] ? PW'(CMPW'(r_rem[s-1][c]) - w_sh[c])
                                           : r_rem[s-1][c];
                    r_q[s][c]   <= r_q[s-1][c] | (w_ge[c] ? (QW'(1) << (QW - s)) : '0);
                    r_neg[s][c] <= r_neg[s-1][c];
                    r_ovr[s][c] <= r_ovr[s-1][c];
                end
                r_dv[s] <= r_dv[s-1];
                r_dm[s] <= r_dm[s-1];
            end
        end
    end

    logic [QW-1:0] qc [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            qc[c] = (r_ovr[QW][c] || r_q[QW][c] > QLIM) ? QLIM : r_q[QW][c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_pf_q[c] <= r_neg[QW][c] ? -$signed({1'b0, qc[c]}) : $signed({1'b0, qc[c]});
            end
            r_pf_m <= r_dm[QW];
        end
    end

    // Final add and saturation; items that use corner b as it is skip both.
    tpi_pkg::t_result  push_d;
    logic signed [SW-1:0] sum [3];
    logic              push, pop;

    always_comb begin
        push_d = r_pf_m.res;
        for (int c = 0; c < 3; c++) begin
            sum[c] = SW'($signed(r_pf_m.res.pt[c])) + SW'(r_pf_q[c]);
            if (!r_pf_m.use_b) begin
                if (sum[c][SW-1:CW-1] == '0 || sum[c][SW-1:CW-1] == '1) begin
                    push_d.pt[c] = sum[c][CW-1:0];
                end else if (sum[c][SW-1]) begin
                    push_d.pt[c] = {1'b1, {(CW-1){1'b0}}};
                end else begin
                    push_d.pt[c] = {1'b0, {(CW-1){1'b1}}};
                end
            end
        end
    end

    // Two-entry output buffer; the head drives the ports.
    tpi_pkg::t_result r_q0, r_q1;

    assign push = en && r_pf_v;
    assign pop  = (r_ocnt != 2'd0) && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= 2'd0;
        end else begin
            r_ocnt <= r_ocnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_ocnt)
            2'd0: begin
                if (push) r_q0 <= push_d;
            end
            2'd1: begin
                if (push && pop) begin
                    r_q0 <= push_d;
                end else if (push) begin
                    r_q1 <= push_d;
                end
            end
            default: begin
                if (pop) r_q0 <= r_q1;
            end
        endcase
    end

    assign o_out_valid   = (r_ocnt != 2'd0);
    assign o_point_x     = $signed(r_q0.pt[0]);
    assign o_point_y     = $signed(r_q0.pt[1]);
    assign o_point_z     = $signed(r_q0.pt[2]);
    assign o_point_valid = r_q0.pv;
    assign o_hit_case    = r_q0.hc;
    assign o_tri_end     = r_q0.last;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v |-> (r_idx < r_s_cnt))
        else $error("result index ran past the triangle's result count");

    a_miss_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_point_valid) |-> (o_tri_end && o_hit_case == tpi_pkg::HC_NONE
            && o_point_x == 0 && o_point_y == 0 && o_point_z == 0))
        else $error("miss item is not a lone zero item");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_f1_v)
        else $error("accepted item did not enter the first stage");

endmodule
